### src/mqtt_publish_deframer_unit_assert.svh
// assertion macros for the mqtt publish deframer
`ifndef MQTT_PUBLISH_DEFRAMER_UNIT_ASSERT_SVH
`define MQTT_PUBLISH_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled during reset
`define MPD_ASSERT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (con)) \
    else $error(msg);
// next-cycle implication, disabled during reset
`define MPD_ASSERT_NXT(lbl, pre, con, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (con)) \
    else $error(msg);
`else
`define MPD_ASSERT(lbl, pre, con, msg)
`define MPD_ASSERT_NXT(lbl, pre, con, msg)
`endif
`endif

### src/mpd_pkg.sv
// shared types and constants of the mqtt publish deframer
package mpd_pkg;

  localparam int MAX_MESSAGE_DEF = 1024;
  localparam int TOPIC_BYTES_DEF = 32;
  localparam int TOPIC_MAX       = 32;
  localparam int TOPIC_IDX_W     = $clog2(TOPIC_MAX);
  localparam int RL_W            = 28;
  localparam int TL_W            = 16;
  localparam int LBS_W           = 3;
  localparam int OUT_LEN_W       = 11;

  localparam logic [7:0] HDR_PUBLISH_QOS0 = 8'h30;

  typedef enum logic [3:0] {
    ST_OK           = 4'd0,
    ST_TOO_SHORT    = 4'd1,
    ST_NOT_PUBLISH  = 4'd2,
    ST_LENGTH_CUT   = 4'd3,
    ST_BAD_REMAIN   = 4'd4,
    ST_BAD_TOPICLEN = 4'd5,
    ST_TOPIC_MISM   = 4'd6,
    ST_EMPTY_PAY    = 4'd7,
    ST_OVERFLOW     = 4'd8
  } status_e;

  // chunk flags captured with the last byte
  typedef struct packed {
    logic overflow;
    logic too_short;
    logic header_ok;
    logic length_done;
    logic mismatch;
  } snap_flags_t;

endpackage

### src/mpd_parser.sv
// per-byte chunk parser with snapshot of the chunk state on the last byte
module mpd_parser #(
  parameter int MAX_MESSAGE = mpd_pkg::MAX_MESSAGE_DEF,
  parameter int TOPIC_BYTES = mpd_pkg::TOPIC_BYTES_DEF,
  localparam int IW = $clog2(MAX_MESSAGE + 2)
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  take_i,
  input  logic [7:0]                            byte_i,
  input  logic                                  last_i,
  input  logic [mpd_pkg::TOPIC_MAX-1:0][7:0]    topic_i,
  output mpd_pkg::snap_flags_t                  snap_flags_o,
  output logic [mpd_pkg::RL_W-1:0]              snap_rl_o,
  output logic [mpd_pkg::TL_W-1:0]              snap_tl_o,
  output logic [IW-1:0]                         snap_lei_o,
  output logic [IW-1:0]                         snap_len_o
);
  import mpd_pkg::*;

  logic [IW-1:0]    idx_q, idx_d;
  logic             hok_q, hok_d;
  logic             ldone_q, ldone_d;
  logic [LBS_W-1:0] lbs_q, lbs_d;
  logic [RL_W-1:0]  rl_q, rl_d;
  logic [IW-1:0]    lei_q, lei_d;
  logic [TL_W-1:0]  tl_q, tl_d;
  logic [TL_W-1:0]  tpos_q, tpos_d;
  logic             mism_q, mism_d;
  logic             stop_q, stop_d;

  logic [4:0]       shamt;
  logic [7:0]       exp_byte;

  // shift of the current base-128 group
  always_comb begin
    unique case (lbs_q[1:0])
      2'd0:    shamt = 5'd0;
      2'd1:    shamt = 5'd7;
      2'd2:    shamt = 5'd14;
      default: shamt = 5'd21;
    endcase
  end

  // expected topic byte, zero past the configured topic size
  always_comb begin
    if (tpos_q < TL_W'(TOPIC_BYTES)) begin
      exp_byte = topic_i[tpos_q[TOPIC_IDX_W-1:0]];
    end else begin
      exp_byte = 8'h00;
    end
  end

  // next chunk state for the byte at hand
  always_comb begin
    idx_d   = idx_q;
    hok_d   = hok_q;
    ldone_d = ldone_q;
    lbs_d   = lbs_q;
    rl_d    = rl_q;
    lei_d   = lei_q;
    tl_d    = tl_q;
    tpos_d  = tpos_q;
    mism_d  = mism_q;
    stop_d  = stop_q;
    if (idx_q >= IW'(MAX_MESSAGE)) begin
      idx_d = IW'(MAX_MESSAGE + 1);
    end else begin
      idx_d = idx_q + IW'(1);
      priority if (idx_q == '0) begin
        hok_d = (byte_i == HDR_PUBLISH_QOS0);
      end else if (!ldone_q) begin
        rl_d  = rl_q + (RL_W'(byte_i[6:0]) << shamt);
        lbs_d = lbs_q + LBS_W'(1);
        if (!byte_i[7] || lbs_q >= LBS_W'(3)) begin
          ldone_d = 1'b1;
          lei_d   = idx_q + IW'(1);
        end
      end else if (idx_q == lei_q) begin
        tl_d = {byte_i, 8'h00};
      end else if (idx_q == lei_q + IW'(1)) begin
        tl_d = tl_q | {8'h00, byte_i};
      end else begin
        // topic bytes are compared, payload and trailing bytes only counted
        if (tpos_q < tl_q) begin
          if (!mism_q && !stop_q) begin
            if (byte_i != exp_byte) begin
              mism_d = 1'b1;
            end else if (byte_i == 8'h00) begin
              stop_d = 1'b1;
            end
          end
          tpos_d = tpos_q + TL_W'(1);
        end
      end
    end
  end

  // chunk state, cleared after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      hok_q   <= 1'b0;
      ldone_q <= 1'b0;
      lbs_q   <= '0;
      rl_q    <= '0;
      lei_q   <= '0;
      tl_q    <= '0;
      tpos_q  <= '0;
      mism_q  <= 1'b0;
      stop_q  <= 1'b0;
    end else if (take_i) begin
      if (last_i) begin
        idx_q   <= '0;
        hok_q   <= 1'b0;
        ldone_q <= 1'b0;
        lbs_q   <= '0;
        rl_q    <= '0;
        lei_q   <= '0;
        tl_q    <= '0;
        tpos_q  <= '0;
        mism_q  <= 1'b0;
        stop_q  <= 1'b0;
      end else begin
        idx_q   <= idx_d;
        hok_q   <= hok_d;
        ldone_q <= ldone_d;
        lbs_q   <= lbs_d;
        rl_q    <= rl_d;
        lei_q   <= lei_d;
        tl_q    <= tl_d;
        tpos_q  <= tpos_d;
        mism_q  <= mism_d;
        stop_q  <= stop_d;
      end
    end
  end

  // snapshot for the verdict stage
  always_ff @(posedge clk_i) begin
    if (take_i && last_i) begin
      snap_flags_o.overflow    <= (idx_d > IW'(MAX_MESSAGE));
      snap_flags_o.too_short   <= (idx_d <= IW'(2));
      snap_flags_o.header_ok   <= hok_d;
      snap_flags_o.length_done <= ldone_d;
      snap_flags_o.mismatch    <= mism_d;
      snap_rl_o                <= rl_d;
      snap_tl_o                <= tl_d;
      snap_lei_o               <= lei_d;
      snap_len_o               <= idx_d;
    end
  end

endmodule

### src/mqtt_publish_deframer_unit.sv
// top level of the mqtt publish deframer: config registers, verdict stage, output
//
// usage:
//   the slave stream takes one received byte per transfer in tdata[7:0], with
//   tlast on the final byte of a chunk. every byte is parsed in the cycle it is
//   taken; one byte per cycle is sustained while the result stages have room.
//   a chunk gives exactly one result, on its last byte, on the master stream:
//   status, payload offset and payload length.
//   the chunk state is captured in the snapshot register on the transfer of
//   the last byte; the verdict is then registered in the output register,
//   which drives the master stream.
//   the apb port holds four 64-bit words of the expected topic at byte
//   addresses 0, 8, 16, 24; pready is always high. write the topic only
//   while no chunk is in flight.
//   reset clears the topic words, the chunk state and the valid flags of both result stages.
//   when the receiver stalls the result holds in the output register; one
//   more result waits in the snapshot stage, and only then does the input
//   stop taking bytes.
module mqtt_publish_deframer_unit #(
  parameter int MAX_MESSAGE = mpd_pkg::MAX_MESSAGE_DEF,
  parameter int TOPIC_BYTES = mpd_pkg::TOPIC_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,
  // master stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [3:0] status, [14:4] payload_offset,
                                        // [25:15] payload_length, [31:26] zero
  // configuration
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output logic [63:0] prdata_o,
  output logic        pready_o
);
  import mpd_pkg::*;

  localparam int IW = $clog2(MAX_MESSAGE + 2);

  logic [3:0][63:0]           topic_q;
  logic [TOPIC_MAX-1:0][7:0]  topic_bytes;

  logic                       s_acc;
  logic                       out_free;
  logic                       snap_valid_q;
  snap_flags_t                snap_flags;
  logic [RL_W-1:0]            snap_rl;
  logic [TL_W-1:0]            snap_tl;
  logic [IW-1:0]              snap_lei;
  logic [IW-1:0]              snap_len;

  logic [IW-1:0]              avail;
  logic [TL_W:0]              tl_plus2;
  logic [RL_W-1:0]            payload;
  status_e                    st;
  logic [OUT_LEN_W-1:0]       off;
  logic [OUT_LEN_W-1:0]       plen;

  logic                       m_valid_q;
  status_e                    st_q;
  logic [OUT_LEN_W-1:0]       off_q;
  logic [OUT_LEN_W-1:0]       plen_q;

  // apb register file
  assign pready_o = 1'b1;
  assign prdata_o = topic_q[paddr_i[4:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      topic_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && pready_o) begin
      topic_q[paddr_i[4:3]] <= pwdata_i;
    end
  end

  assign topic_bytes = topic_q;

  // input handshake
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !snap_valid_q || out_free;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;

  mpd_parser #(
    .MAX_MESSAGE (MAX_MESSAGE),
    .TOPIC_BYTES (TOPIC_BYTES)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (s_acc),
    .byte_i       (s_axis_tdata_i),
    .last_i       (s_axis_tlast_i),
    .topic_i      (topic_bytes),
    .snap_flags_o (snap_flags),
    .snap_rl_o    (snap_rl),
    .snap_tl_o    (snap_tl),
    .snap_lei_o   (snap_lei),
    .snap_len_o   (snap_len)
  );

  // snapshot stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
    end else if (s_acc && s_axis_tlast_i) begin
      snap_valid_q <= 1'b1;
    end else if (out_free) begin
      snap_valid_q <= 1'b0;
    end
  end

  // verdict in priority order
  assign avail    = snap_len - snap_lei;
  assign tl_plus2 = (TL_W + 1)'(snap_tl) + (TL_W + 1)'(2);
  assign payload  = snap_rl - RL_W'(tl_plus2);

  always_comb begin
    off  = '0;
    plen = '0;
    priority if (snap_flags.overflow) begin
      st = ST_OVERFLOW;
    end else if (snap_flags.too_short) begin
      st = ST_TOO_SHORT;
    end else if (!snap_flags.header_ok) begin
      st = ST_NOT_PUBLISH;
    end else if (!snap_flags.length_done) begin
      st = ST_LENGTH_CUT;
    end else if (snap_rl <= RL_W'(2) || snap_rl > RL_W'(avail)) begin
      st = ST_BAD_REMAIN;
    end else if ((IW + 1)'(snap_lei) + (IW + 1)'(2) > (IW + 1)'(snap_len)) begin
      st = ST_LENGTH_CUT;
    end else if (snap_tl == '0 || RL_W'(tl_plus2) > snap_rl) begin
      st = ST_BAD_TOPICLEN;
    end else if (snap_flags.mismatch) begin
      st = ST_TOPIC_MISM;
    end else if (payload == '0) begin
      st = ST_EMPTY_PAY;
    end else begin
      st   = ST_OK;
      off  = OUT_LEN_W'(snap_lei) + OUT_LEN_W'(2) + OUT_LEN_W'(snap_tl);
      plen = OUT_LEN_W'(payload);
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_free) begin
      m_valid_q <= snap_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && snap_valid_q) begin
      st_q   <= st;
      off_q  <= off;
      plen_q <= plen;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {6'b0, plen_q, off_q, st_q};

  `include "mqtt_publish_deframer_unit_assert.svh"

  `MPD_ASSERT(a_snap_free, s_acc && s_axis_tlast_i, !snap_valid_q || out_free, "snapshot overrun")
  `MPD_ASSERT_NXT(a_snap_moves, snap_valid_q && out_free, m_valid_q, "verdict transfer lost")
  `MPD_ASSERT(a_fail_zero, m_valid_q && st_q != ST_OK, off_q == '0 && plen_q == '0, "fields set on failure")
  `MPD_ASSERT(a_status_range, m_valid_q, st_q <= ST_OVERFLOW, "status code out of range")

endmodule
